// File: design/overwriting_log_ring_buffer_top_assert.svh
// assertion macros used by the checker file olrb_checker.sv
`ifndef OVERWRITING_LOG_RING_BUFFER_TOP_ASSERT_SVH
`define OVERWRITING_LOG_RING_BUFFER_TOP_ASSERT_SVH

// same-cycle implication, checked at each rising edge outside reset
`define OLRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at each rising edge outside reset
`define OLRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/olrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package olrb_pkg;

    // store geometry, depth is a power of two
    localparam int STORE_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    localparam logic [11:0] LINE_LIMIT_RESET   = 12'd383;
    localparam logic [15:0] TAIL_DEFAULT_LINES = 16'd50;
    localparam logic [7:0]  NEWLINE_CODE       = 8'h0A;

    // transaction kinds
    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_FULL   = 3'd1,
        KIND_TAIL   = 3'd2,
        KIND_FETCH  = 3'd3,
        KIND_CLEAR  = 3'd4,
        KIND_DROP   = 3'd5
    } kind_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // register index of the line limit
    localparam logic REG_LINE_LIMIT = 1'b0;

endpackage

`default_nettype wire

// File: design/overwriting_log_ring_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte ring buffer for log text with overwrite of the oldest data. An item is
// taken when start is high and busy is low. Its result appears on the result
// ports for exactly one cycle, marked by done, in the cycle after the item
// finishes, and the receiver cannot stall it. Appends, full-read starts, byte
// fetches, clears and dropped-line events finish in the accept cycle, so one
// item can be taken every cycle. A tail-read start walks the store backwards
// through its single read port, one byte per cycle with one pipelined read in
// flight, and busy stays high until the wanted newline is found or, when too
// few newlines are held, until all of the held data is walked. busy drops
// with no walk when the store is empty. done rises in the same cycle that
// busy drops. The store needs no clearing pass after reset; it is only read
// where it was written. The line limit register sits at byte address 0 of
// the APB-style port.
module overwriting_log_ring_buffer_top (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  data_byte,
    input  logic        end_of_line,
    input  logic [15:0] line_count,
    input  logic [15:0] read_limit,
    // result channel
    output logic        done,
    output logic [7:0]  read_byte,
    output logic        byte_valid,
    output logic        last_byte,
    output logic [15:0] read_length,
    output logic [15:0] fill_level,
    output logic [31:0] line_tally,
    output logic [31:0] drop_tally,
    output logic [31:0] byte_tally,
    output logic [31:0] overwrite_tally,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import olrb_pkg::*;

    // read length clamped to the transaction's byte limit
    function automatic logic [COUNT_W-1:0] clamp_len(input logic [COUNT_W-1:0] len,
                                                     input logic [15:0] lim);
        logic [COUNT_W-1:0] res;
        begin
            if (32'(len) > 32'(lim))
                res = COUNT_W'(lim);
            else
                res = len;
            return res;
        end
    endfunction

    // text store
    logic [7:0]        mem [STORE_DEPTH];
    logic              mem_wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;

    // control and status registers
    state_t             state_reg, state_next;
    logic [11:0]        limit_reg, limit_next;
    logic [ADDR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [COUNT_W-1:0] valid_reg, valid_next;
    logic [31:0]        lines_reg, lines_next;
    logic [31:0]        dropped_reg, dropped_next;
    logic [31:0]        bytes_reg, bytes_next;
    logic [31:0]        over_reg, over_next;
    logic [11:0]        line_bytes_reg, line_bytes_next;
    logic [ADDR_W-1:0]  cursor_reg, cursor_next;
    logic [COUNT_W-1:0] remaining_reg, remaining_next;
    logic [COUNT_W-1:0] span_reg, span_next;
    logic               done_reg, done_next;
    logic               byte_valid_reg, byte_valid_next;
    logic               last_byte_reg, last_byte_next;

    // tail scan registers
    logic [15:0]        want_reg, want_next;
    logic [15:0]        tail_limit_reg, tail_limit_next;
    logic [ADDR_W-1:0]  scan_ptr_reg, scan_ptr_next;
    logic [COUNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic               pend_reg, pend_next;
    logic [COUNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [15:0]        found_reg, found_next;

    logic              accept;
    logic              cfg_write;
    logic [ADDR_W-1:0] oldest_pos;
    logic [ADDR_W-1:0] scan_prev;
    logic [16:0]       found_inc;
    logic              scan_hit;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign oldest_pos = wr_pos_reg - valid_reg[ADDR_W-1:0];
    assign scan_prev  = scan_ptr_reg - ADDR_W'(1);
    assign found_inc  = {1'b0, found_reg} + 17'd1;
    assign scan_hit   = pend_reg && (rd_data_reg == NEWLINE_CODE);

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[wr_pos_reg] <= data_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= LINE_LIMIT_RESET;
            wr_pos_reg     <= '0;
            valid_reg      <= '0;
            lines_reg      <= '0;
            dropped_reg    <= '0;
            bytes_reg      <= '0;
            over_reg       <= '0;
            line_bytes_reg <= '0;
            cursor_reg     <= '0;
            remaining_reg  <= '0;
            span_reg       <= '0;
            done_reg       <= 1'b0;
            byte_valid_reg <= 1'b0;
            last_byte_reg  <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            limit_reg      <= limit_next;
            wr_pos_reg     <= wr_pos_next;
            valid_reg      <= valid_next;
            lines_reg      <= lines_next;
            dropped_reg    <= dropped_next;
            bytes_reg      <= bytes_next;
            over_reg       <= over_next;
            line_bytes_reg <= line_bytes_next;
            cursor_reg     <= cursor_next;
            remaining_reg  <= remaining_next;
            span_reg       <= span_next;
            done_reg       <= done_next;
            byte_valid_reg <= byte_valid_next;
            last_byte_reg  <= last_byte_next;
            pend_reg       <= pend_next;
        end
    end

    // scan payload registers
    always_ff @(posedge clk)
    begin
        want_reg       <= want_next;
        tail_limit_reg <= tail_limit_next;
        scan_ptr_reg   <= scan_ptr_next;
        issue_idx_reg  <= issue_idx_next;
        pend_idx_reg   <= pend_idx_next;
        pend_addr_reg  <= pend_addr_next;
        found_reg      <= found_next;
    end

    // sequencer: next state and register updates
    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        wr_pos_next     = wr_pos_reg;
        valid_next      = valid_reg;
        lines_next      = lines_reg;
        dropped_next    = dropped_reg;
        bytes_next      = bytes_reg;
        over_next       = over_reg;
        line_bytes_next = line_bytes_reg;
        cursor_next     = cursor_reg;
        remaining_next  = remaining_reg;
        span_next       = span_reg;
        done_next       = 1'b0;
        byte_valid_next = byte_valid_reg;
        last_byte_next  = last_byte_reg;
        want_next       = want_reg;
        tail_limit_next = tail_limit_reg;
        scan_ptr_next   = scan_ptr_reg;
        issue_idx_next  = issue_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_addr_next  = pend_addr_reg;
        found_next      = found_reg;
        mem_wr_en       = 1'b0;
        rd_addr         = cursor_reg;

        // configuration write
        if (cfg_write && (paddr[2] == REG_LINE_LIMIT))
        begin
            limit_next = pwdata[11:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_next       = 1'b1;
                    byte_valid_next = 1'b0;
                    last_byte_next  = 1'b0;
                    case (kind_t'(kind))
                        KIND_APPEND:
                        begin
                            if (line_bytes_reg < limit_reg)
                            begin
                                mem_wr_en       = 1'b1;
                                wr_pos_next     = wr_pos_reg + ADDR_W'(1);
                                if (valid_reg >= COUNT_W'(STORE_DEPTH))
                                    over_next = over_reg + 32'd1;
                                else
                                    valid_next = valid_reg + COUNT_W'(1);
                                bytes_next      = bytes_reg + 32'd1;
                                line_bytes_next = line_bytes_reg + 12'd1;
                            end
                            if (end_of_line)
                            begin
                                lines_next      = lines_reg + 32'd1;
                                line_bytes_next = '0;
                            end
                        end
                        KIND_FULL:
                        begin
                            cursor_next    = oldest_pos;
                            span_next      = clamp_len(valid_reg, read_limit);
                            remaining_next = clamp_len(valid_reg, read_limit);
                        end
                        KIND_TAIL:
                        begin
                            done_next       = 1'b0;
                            want_next       = (line_count == 16'd0) ? TAIL_DEFAULT_LINES
                                                                    : line_count;
                            tail_limit_next = read_limit;
                            scan_ptr_next   = wr_pos_reg;
                            issue_idx_next  = '0;
                            found_next      = '0;
                            state_next      = ST_SCAN;
                        end
                        KIND_FETCH:
                        begin
                            // store read of the cursor lands in rd_data_reg
                            if (remaining_reg != '0)
                            begin
                                byte_valid_next = 1'b1;
                                last_byte_next  = (remaining_reg == COUNT_W'(1));
                                cursor_next     = cursor_reg + ADDR_W'(1);
                                remaining_next  = remaining_reg - COUNT_W'(1);
                            end
                        end
                        KIND_CLEAR:
                        begin
                            wr_pos_next     = '0;
                            valid_next      = '0;
                            lines_next      = '0;
                            dropped_next    = '0;
                            bytes_next      = '0;
                            over_next       = '0;
                            line_bytes_next = '0;
                            cursor_next     = '0;
                            remaining_next  = '0;
                            span_next       = '0;
                        end
                        KIND_DROP:
                        begin
                            dropped_next = dropped_reg + 32'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_addr = scan_prev;
                if (scan_hit && (found_inc >= {1'b0, want_reg}))
                begin
                    // wanted newline found: read starts just after it
                    cursor_next     = pend_addr_reg + ADDR_W'(1);
                    span_next       = clamp_len(pend_idx_reg, tail_limit_reg);
                    remaining_next  = clamp_len(pend_idx_reg, tail_limit_reg);
                    done_next       = 1'b1;
                    byte_valid_next = 1'b0;
                    last_byte_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
                else if (!pend_reg && (issue_idx_reg == valid_reg))
                begin
                    // too few newlines: read all held data
                    cursor_next     = oldest_pos;
                    span_next       = clamp_len(valid_reg, tail_limit_reg);
                    remaining_next  = clamp_len(valid_reg, tail_limit_reg);
                    done_next       = 1'b1;
                    byte_valid_next = 1'b0;
                    last_byte_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    if (scan_hit)
                    begin
                        found_next = found_inc[15:0];
                    end
                    // issue the next older byte
                    if (issue_idx_reg < valid_reg)
                    begin
                        pend_next      = 1'b1;
                        pend_idx_next  = issue_idx_reg;
                        pend_addr_next = scan_prev;
                        scan_ptr_next  = scan_prev;
                        issue_idx_next = issue_idx_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result and status outputs
    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign read_byte       = byte_valid_reg ? rd_data_reg : 8'd0;
    assign byte_valid      = byte_valid_reg;
    assign last_byte       = last_byte_reg;
    assign read_length     = 16'(span_reg);
    assign fill_level      = 16'(valid_reg);
    assign line_tally      = lines_reg;
    assign drop_tally      = dropped_reg;
    assign byte_tally      = bytes_reg;
    assign overwrite_tally = over_reg;

    // configuration read back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_LIMIT) ? {20'd0, limit_reg} : 32'd0;

endmodule

`default_nettype wire

// File: design/olrb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "overwriting_log_ring_buffer_top_assert.svh"

module olrb_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire  [2:0]  kind,
    input  wire         done,
    input  wire  [7:0]  read_byte,
    input  wire         byte_valid,
    input  wire         last_byte,
    input  wire  [15:0] read_length
);
    import olrb_pkg::*;

    // every transaction but a tail read finishes in its accept cycle
    `OLRB_ASSERT_NEXT(a_quick_done, clk, rst_n, (start && !busy && (kind != KIND_TAIL)), done, "no result after single-cycle transaction")

    // a tail read holds the block and gives no immediate result
    `OLRB_ASSERT_NEXT(a_tail_busy, clk, rst_n, (start && !busy && (kind == KIND_TAIL)), (busy && !done), "tail read did not start scanning")

    // a result is only shown with the sequencer idle
    `OLRB_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "result while busy")

    // the last byte is a delivered byte of a nonempty read
    `OLRB_ASSERT_NOW(a_last_valid, clk, rst_n, (done && last_byte), (byte_valid && (read_length != 16'd0)), "last byte without delivered byte")

    // no delivered byte means a zero byte field
    `OLRB_ASSERT_NOW(a_byte_zero, clk, rst_n, (done && !byte_valid), (read_byte == 8'd0), "byte field set without delivery")

endmodule

bind overwriting_log_ring_buffer_top olrb_checker u_olrb_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import olrb_pkg::*;

    localparam int          LIMIT_CYCLES  = 10000000;
    localparam logic [2:0]  KIND_UNUSED_A = 3'd6;
    localparam logic [2:0]  KIND_UNUSED_B = 3'd7;
    localparam logic [2:0]  LIMIT_ADDR    = {REG_LINE_LIMIT, 2'b00};

    // one log command as driven on the command channel
    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        eol;
        logic [15:0] lines;
        logic [15:0] limit;
    } ring_cmd_t;

    // status expected on the result channel
    typedef struct {
        logic [7:0]  rbyte;
        logic        valid;
        logic        last;
        logic [15:0] span;
        logic [15:0] used;
        logic [31:0] lines_w;
        logic [31:0] lines_d;
        logic [31:0] bytes_w;
        logic [31:0] bytes_o;
    } ring_status_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block inputs
    logic        start       = 1'b0;
    logic [2:0]  kind        = 3'd0;
    logic [7:0]  data_byte   = 8'd0;
    logic        end_of_line = 1'b0;
    logic [15:0] line_count  = 16'd0;
    logic [15:0] read_limit  = 16'd0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;

    // block outputs
    logic        busy;
    logic        done;
    logic [7:0]  read_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [15:0] read_length;
    logic [15:0] fill_level;
    logic [31:0] line_tally;
    logic [31:0] drop_tally;
    logic [31:0] byte_tally;
    logic [31:0] overwrite_tally;
    logic [31:0] prdata;
    logic        pready;

    overwriting_log_ring_buffer_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .kind            (kind),
        .data_byte       (data_byte),
        .end_of_line     (end_of_line),
        .line_count      (line_count),
        .read_limit      (read_limit),
        .done            (done),
        .read_byte       (read_byte),
        .byte_valid      (byte_valid),
        .last_byte       (last_byte),
        .read_length     (read_length),
        .fill_level      (fill_level),
        .line_tally      (line_tally),
        .drop_tally      (drop_tally),
        .byte_tally      (byte_tally),
        .overwrite_tally (overwrite_tally),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // command backlog and expected status
    ring_cmd_t    cmd_backlog [$];
    ring_status_t status_due  [$];
    ring_cmd_t    next_cmd;
    ring_status_t due_now;

    int errors          = 0;
    int pushed          = 0;
    int results_checked = 0;
    int bytes_fetched   = 0;
    int tail_reads      = 0;
    int cycles          = 0;
    int burst_left      = 0;
    int gap_left        = 0;

    // ring buffer mirror
    logic [7:0]  ring_mem [0:STORE_DEPTH-1];
    int unsigned wr_pos       = 0;
    int unsigned held         = 0;
    int unsigned line_fill    = 0;
    int unsigned rd_pos       = 0;
    int unsigned rd_left      = 0;
    int unsigned rd_span      = 0;
    int unsigned line_limit_m = LINE_LIMIT_RESET;
    logic [31:0] line_cnt     = 32'd0;
    logic [31:0] drop_cnt     = 32'd0;
    logic [31:0] byte_cnt     = 32'd0;
    logic [31:0] over_cnt     = 32'd0;

    task automatic log_error(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            log_error($sformatf("%s got 0x%0h expected 0x%0h (result %0d)",
                                name, got, want, results_checked));
    endtask

    // start a read, cut to the byte limit
    function automatic void open_read(input int unsigned first, input int unsigned len,
                                      input int unsigned lim);
        if (len > lim)
            len = lim;
        rd_pos  = first;
        rd_left = len;
        rd_span = len;
    endfunction

    // applies one command to the mirror and returns the status it yields
    function automatic ring_status_t ring_apply(input ring_cmd_t c);
        ring_status_t s;
        int unsigned  want;
        int unsigned  found;
        int unsigned  p;
        int unsigned  i;
        int unsigned  first;
        int unsigned  len;
        logic         hit;
        s.rbyte = 8'd0;
        s.valid = 1'b0;
        s.last  = 1'b0;
        first = (wr_pos >= held) ? wr_pos - held : wr_pos + STORE_DEPTH - held;
        case (c.kind)
            KIND_APPEND: begin
                if (line_fill < line_limit_m) begin
                    ring_mem[wr_pos] = c.data;
                    wr_pos = (wr_pos + 1) % STORE_DEPTH;
                    if (held >= STORE_DEPTH)
                        over_cnt++;
                    else
                        held++;
                    byte_cnt++;
                    line_fill++;
                end
                // a line end counts even when its byte was cut off
                if (c.eol) begin
                    line_cnt++;
                    line_fill = 0;
                end
            end
            KIND_FULL: begin
                open_read(first, held, c.limit);
            end
            KIND_TAIL: begin
                // walk back from the newest byte to the wanted newline
                want  = (c.lines == 16'd0) ? TAIL_DEFAULT_LINES : c.lines;
                found = 0;
                hit   = 1'b0;
                p     = wr_pos;
                len   = held;
                for (i = 0; i < held && !hit; i++) begin
                    p = (p == 0) ? STORE_DEPTH - 1 : p - 1;
                    if (ring_mem[p] == NEWLINE_CODE) begin
                        found++;
                        if (found >= want) begin
                            hit   = 1'b1;
                            first = (p + 1) % STORE_DEPTH;
                            len   = i;
                        end
                    end
                end
                open_read(first, len, c.limit);
            end
            KIND_FETCH: begin
                if (rd_left > 0) begin
                    s.rbyte = ring_mem[rd_pos];
                    s.valid = 1'b1;
                    s.last  = (rd_left == 1);
                    rd_pos  = (rd_pos + 1) % STORE_DEPTH;
                    rd_left--;
                end
            end
            KIND_CLEAR: begin
                wr_pos    = 0;
                held      = 0;
                line_fill = 0;
                rd_pos    = 0;
                rd_left   = 0;
                rd_span   = 0;
                line_cnt  = 32'd0;
                drop_cnt  = 32'd0;
                byte_cnt  = 32'd0;
                over_cnt  = 32'd0;
            end
            KIND_DROP: begin
                drop_cnt++;
            end
            default: begin
            end
        endcase
        s.span    = 16'(rd_span);
        s.used    = 16'(held);
        s.lines_w = line_cnt;
        s.lines_d = drop_cnt;
        s.bytes_w = byte_cnt;
        s.bytes_o = over_cnt;
        return s;
    endfunction

    // stimulus helpers
    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void push_cmd(input logic [2:0] k, input logic [7:0] d, input logic e,
                                     input logic [15:0] n, input logic [15:0] lim);
        ring_cmd_t c;
        c.kind  = k;
        c.data  = d;
        c.eol   = e;
        c.lines = n;
        c.limit = lim;
        cmd_backlog.push_back(c);
        pushed++;
    endfunction

    function automatic void push_byte(input logic [7:0] d, input logic e);
        push_cmd(KIND_APPEND, d, e, rnd16(), rnd16());
    endfunction

    function automatic void push_op(input logic [2:0] k, input logic [15:0] n,
                                    input logic [15:0] lim);
        push_cmd(k, 8'($urandom), 1'($urandom), n, lim);
    endfunction

    // random text bytes, then a newline that ends the line
    function automatic void push_line(input int len);
        int k;
        for (k = 1; k < len; k++)
            push_byte(8'($urandom), 1'b0);
        push_byte(NEWLINE_CODE, 1'b1);
    endfunction

    function automatic logic [15:0] pick_lines();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1, 2, 3: return 16'($urandom_range(1, 4));
            4:       return 16'($urandom_range(5, 60));
            default: return rnd16();
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'($urandom_range(1, 8));
            4:       return 16'($urandom_range(0, 400));
            default: return rnd16();
        endcase
    endfunction

    // mostly whole lines and read-then-fetch runs, with some noise
    task automatic random_traffic(input int n, input int line_max);
        int target;
        int r;
        int k;
        int runs;
        target = pushed + n;
        while (pushed < target) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                push_line($urandom_range(1, line_max));
            end else if (r < 62) begin
                push_op((r < 52) ? KIND_TAIL : KIND_FULL, pick_lines(), pick_limit());
                runs = $urandom_range(1, 48);
                for (k = 0; k < runs; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        push_byte(8'($urandom), 1'($urandom));
                    push_op(KIND_FETCH, rnd16(), rnd16());
                end
            end else if (r < 72) begin
                push_op(KIND_FETCH, rnd16(), rnd16());
            end else if (r < 78) begin
                push_op(KIND_DROP, rnd16(), rnd16());
            end else if (r < 80) begin
                push_op(KIND_CLEAR, rnd16(), rnd16());
            end else if (r < 84) begin
                push_op($urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B, rnd16(), rnd16());
            end else if (r < 94) begin
                push_byte(8'($urandom), 1'($urandom));
            end else begin
                // newline byte that does not end the line
                push_byte(NEWLINE_CODE, 1'b0);
            end
        end
    endtask

    // wait until every command has gone out and every status has come back
    task automatic wait_idle();
        @(negedge clk);
        while (cmd_backlog.size() != 0 || start || status_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register transaction; a read compares with the given value
    task automatic apb_access(input logic wr, input logic [11:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (!wr && prdata !== 32'(value))
            log_error($sformatf("line limit reads 0x%0h expected 0x%0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_line_limit(input logic [11:0] value);
        wait_idle();
        apb_access(1'b1, value);
        line_limit_m = value;
        apb_access(1'b0, value);
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                next_cmd     = cmd_backlog.pop_front();
                kind        <= next_cmd.kind;
                data_byte   <= next_cmd.data;
                end_of_line <= next_cmd.eol;
                line_count  <= next_cmd.lines;
                read_limit  <= next_cmd.limit;
                start       <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    if ($urandom_range(0, 3) == 0)
                        gap_left <= 0;
                    else
                        gap_left <= $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check each status, then predict for the accepted transaction
    always @(posedge clk) begin
        if (rst_n) begin
            if (done) begin
                if (status_due.size() == 0) begin
                    log_error("status strobe with no command outstanding");
                end else begin
                    due_now = status_due.pop_front();
                    cmp_field("read_byte", 32'(read_byte), 32'(due_now.rbyte));
                    cmp_field("byte_valid", 32'(byte_valid), 32'(due_now.valid));
                    cmp_field("last_byte", 32'(last_byte), 32'(due_now.last));
                    cmp_field("read_length", 32'(read_length), 32'(due_now.span));
                    cmp_field("fill_level", 32'(fill_level), 32'(due_now.used));
                    cmp_field("line_tally", line_tally, due_now.lines_w);
                    cmp_field("drop_tally", drop_tally, due_now.lines_d);
                    cmp_field("byte_tally", byte_tally, due_now.bytes_w);
                    cmp_field("overwrite_tally", overwrite_tally, due_now.bytes_o);
                    results_checked++;
                    if (due_now.valid)
                        bytes_fetched++;
                end
            end
            if (start && !busy) begin
                if (kind == KIND_TAIL)
                    tail_reads++;
                status_due.push_back(ring_apply('{kind, data_byte, end_of_line,
                                                  line_count, read_limit}));
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d status words outstanding",
                     cycles, status_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // test sequence
    initial begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        apb_access(1'b0, LINE_LIMIT_RESET);

        // empty buffer reads and fetches
        push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_FULL, rnd16(), 16'hFFFF);
        push_op(KIND_TAIL, 16'd0, 16'hFFFF);
        // short lines, including a line end without a newline
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(NEWLINE_CODE, 1'b1);
        push_byte(8'h5A, 1'b0);
        push_byte(NEWLINE_CODE, 1'b1);
        push_byte(8'hA5, 1'b1);
        push_op(KIND_DROP, rnd16(), rnd16());
        push_op(KIND_UNUSED_A, rnd16(), rnd16());
        push_op(KIND_UNUSED_B, rnd16(), rnd16());
        // newest line, then a tail read short of newlines cut to four bytes
        push_op(KIND_TAIL, 16'd1, 16'hFFFF);
        push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_TAIL, 16'd0, 16'd4);
        for (k = 0; k < 5; k++)
            push_op(KIND_FETCH, rnd16(), rnd16());
        // zero read limit, then an append while a read is open, then clear
        push_op(KIND_FULL, rnd16(), 16'd0);
        push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_FULL, rnd16(), 16'h8000);
        push_byte(8'h33, 1'b0);
        push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_CLEAR, rnd16(), rnd16());
        push_op(KIND_FETCH, rnd16(), rnd16());

        // line limit extremes
        set_line_limit(12'd0);
        push_line(3);
        push_op(KIND_FULL, rnd16(), 16'hFFFF);
        push_op(KIND_FETCH, rnd16(), rnd16());
        set_line_limit(12'd1);
        push_line(3);
        push_line(1);
        push_op(KIND_TAIL, 16'd2, 16'hFFFF);
        push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_FETCH, rnd16(), rnd16());
        set_line_limit(12'd4095);
        push_line(20);
        set_line_limit(LINE_LIMIT_RESET);
        push_line(400);
        push_op(KIND_TAIL, 16'd1, 16'hFFFF);
        push_op(KIND_FETCH, rnd16(), rnd16());

        // random traffic under several line limits
        set_line_limit(12'($urandom_range(9, 4094)));
        random_traffic(180, 80);
        set_line_limit(12'($urandom_range(2, 8)));
        random_traffic(180, 16);
        set_line_limit(12'd4095);
        random_traffic(150, 120);
        set_line_limit(LINE_LIMIT_RESET);
        random_traffic(100, 60);

        // tail and full reads over the text held at the end
        wait_idle();
        push_op(KIND_TAIL, 16'd5, 16'hFFFF);
        for (k = 0; k < 40; k++)
            push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_TAIL, 16'hFFFF, 16'h8000);
        for (k = 0; k < 10; k++)
            push_op(KIND_FETCH, rnd16(), rnd16());
        push_op(KIND_FULL, rnd16(), 16'h8000);
        for (k = 0; k < 24; k++)
            push_op(KIND_FETCH, rnd16(), rnd16());

        wait_idle();
        repeat (40) @(negedge clk);
        if (status_due.size() != 0)
            log_error($sformatf("%0d status words never arrived", status_due.size()));
        $display("%0d commands sent, %0d status words checked, %0d bytes fetched, %0d tail reads",
                 pushed, results_checked, bytes_fetched, tail_reads);
        $display("line limits 0, 1, 383, 4095 and random; reads cut by zero, small and wide limits");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
